FILE: rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Types and codes shared by the process slot table and its testbench.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int PRIORITY_MAX = 255;
  localparam int LAUNCH_LIMIT = 32;
  localparam int NUMBER_W     = 15;

  typedef enum logic [1:0] {
    KIND_CREATE    = 2'd0,
    KIND_TERMINATE = 2'd1,
    KIND_PRIORITY  = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PARAM   = 3'd1,
    ST_ID      = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [NUMBER_W-1:0]   assigned_id;
    logic                  launch_request;
  } result_t;

endpackage

FILE: rtl/pst_if.sv
// ----------------------------------------------------------------------------
// pst_in_if / pst_out_if
// Valid/ready channels carrying process table requests and their results.
// ----------------------------------------------------------------------------
interface pst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] process_id;
  logic signed [15:0] priority_value;
  logic signed [31:0] exit_value;
  logic               has_message;

  modport source (output valid, kind, process_id, priority_value, exit_value,
                  has_message, input ready);
  modport sink   (input valid, kind, process_id, priority_value, exit_value,
                  has_message, output ready);
endinterface

interface pst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [14:0] assigned_id;
  logic        launch_request;

  modport source (output valid, status, assigned_id, launch_request, input ready);
  modport sink   (input valid, status, assigned_id, launch_request, output ready);
endinterface

FILE: rtl/process_slot_table_top.sv
// ----------------------------------------------------------------------------
// process_slot_table_top
// Process slot table: create, terminate and change-priority requests.
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one request item (kind, process_id, priority_value,
//   exit_value, has_message); out_ch returns exactly one result item per
//   request (status, assigned_id, launch_request), in request order.
//   parameter checks run when the item is taken; a request that passes them
//   scans the slots one per cycle through a single read port on the number
//   store and one shared match compare, stopping at the first matching slot.
//   in_ready is high only while no request is in progress.
//   an output register holds a finished result; while the receiver stalls
//   one further request may be taken and worked on, and its result waits
//   until the output register is free.
//   reset (rst_n low, synchronous) leaves slot 0 active with number 0, all
//   other slots free and the number counter at 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module process_slot_table_top #(
  parameter int SLOT_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pst_in_if.sink     in_ch,
  pst_out_if.source  out_ch
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam int NW = pst_pkg::NUMBER_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // request fields held for the scan
  logic [1:0]         kind_r;
  logic signed [15:0] id_r;
  logic [7:0]         pri_r;
  logic [31:0]        exit_r;
  logic               msg_r;

  logic [NW-1:0]         cnt_r, cnt_nxt;
  logic [SLOT_COUNT-1:0] active_r, active_nxt;

  // scan pipeline: issue stage reads, check stage compares
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             issue_r, issue_nxt;
  logic             chk_v_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             chk_act_r;
  logic [NW-1:0]    num_rd_r;

  pst_pkg::result_t res_r, res_nxt;
  pst_pkg::result_t out_res_r;
  logic             out_valid_r;

  logic [NW-1:0] slot_num_mem [SLOT_COUNT];
  logic [7:0]    slot_pri_mem [SLOT_COUNT];
  logic [31:0]   slot_exit_mem[SLOT_COUNT];

  logic in_fire, out_free;
  logic pri_bad, id_big, term_bad, prio_bad;
  logic [NW-1:0] num_eff;
  logic match, hit, last_miss;
  logic num_we, pri_we, exit_we;
  logic [31:0] exit_wdata;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // early checks on the incoming item
  assign pri_bad  = in_ch.priority_value[15] ||
                    (in_ch.priority_value > 16'(pst_pkg::PRIORITY_MAX));
  assign id_big   = (int'(in_ch.process_id) >= SLOT_COUNT);
  assign term_bad = in_ch.process_id[15] || (in_ch.process_id == 16'sd0) || id_big;
  assign prio_bad = in_ch.process_id[15] || id_big;

  // slot 0 number is never written and stays 0
  assign num_eff = (chk_idx_r == '0) ? '0 : num_rd_r;
  assign match   = ({1'b0, num_eff} == id_r);
  assign hit     = chk_v_r && ((kind_r == pst_pkg::KIND_CREATE) ? !chk_act_r
                                                                : (chk_act_r && match));
  assign last_miss = chk_v_r && !hit && (chk_idx_r == LAST_IDX);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    issue_nxt  = issue_r;
    res_nxt    = res_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    num_we     = 1'b0;
    pri_we     = 1'b0;
    exit_we    = 1'b0;
    exit_wdata = exit_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '{status: pst_pkg::ST_OK, assigned_id: '0, launch_request: 1'b0};
          idx_nxt   = IDX_W'(1);
          issue_nxt = 1'b1;
          state_nxt = S_SCAN;
          case (in_ch.kind)
            pst_pkg::KIND_CREATE: begin
              if (pri_bad) begin
                res_nxt.status = pst_pkg::ST_PARAM;
                state_nxt      = S_DONE;
              end
            end
            pst_pkg::KIND_TERMINATE: begin
              if (term_bad) begin
                res_nxt.status = pst_pkg::ST_ID;
                state_nxt      = S_DONE;
              end
            end
            pst_pkg::KIND_PRIORITY: begin
              idx_nxt = '0;
              if (pri_bad) begin
                res_nxt.status = pst_pkg::ST_PARAM;
                state_nxt      = S_DONE;
              end else if (prio_bad) begin
                res_nxt.status = pst_pkg::ST_ID;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              res_nxt.status = pst_pkg::ST_PARAM;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          if (idx_r == LAST_IDX) issue_nxt = 1'b0;
          else idx_nxt = idx_r + IDX_W'(1);
        end
        if (hit) begin
          state_nxt = S_DONE;
          issue_nxt = 1'b0;
          case (kind_r)
            pst_pkg::KIND_CREATE: begin
              active_nxt[chk_idx_r] = 1'b1;
              num_we     = 1'b1;
              pri_we     = 1'b1;
              exit_we    = 1'b1;
              exit_wdata = '0;
              res_nxt.assigned_id    = cnt_r;
              res_nxt.launch_request = msg_r && (cnt_r < NW'(pst_pkg::LAUNCH_LIMIT));
              if (cnt_r != '1) cnt_nxt = cnt_r + NW'(1);
            end
            pst_pkg::KIND_TERMINATE: begin
              active_nxt[chk_idx_r] = 1'b0;
              exit_we = 1'b1;
            end
            default: begin
              pri_we = 1'b1;
            end
          endcase
        end else if (last_miss) begin
          state_nxt      = S_DONE;
          res_nxt.status = (kind_r == pst_pkg::KIND_CREATE) ? pst_pkg::ST_FULL
                                                            : pst_pkg::ST_MISSING;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      chk_v_r     <= 1'b0;
      cnt_r       <= NW'(1);
      active_r    <= SLOT_COUNT'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issue_r  <= issue_nxt;
      chk_v_r  <= (state_r == S_SCAN) && issue_r && !hit;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)              out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    chk_idx_r <= idx_r;
    chk_act_r <= active_r[idx_r];
    if (in_fire) begin
      kind_r <= in_ch.kind;
      id_r   <= in_ch.process_id;
      pri_r  <= in_ch.priority_value[7:0];
      exit_r <= in_ch.exit_value;
      msg_r  <= in_ch.has_message;
    end
    if (state_r == S_DONE && out_free) out_res_r <= res_r;
  end

  // slot stores
  always_ff @(posedge clk) begin
    if (num_we)  slot_num_mem[chk_idx_r]  <= cnt_r;
    if (pri_we)  slot_pri_mem[chk_idx_r]  <= pri_r;
    if (exit_we) slot_exit_mem[chk_idx_r] <= exit_wdata;
    num_rd_r <= slot_num_mem[idx_r];
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.assigned_id    = out_res_r.assigned_id;
  assign out_ch.launch_request = out_res_r.launch_request;

  // checks
  a_slot0_active: assert property (@(posedge clk) disable iff (!rst_n)
    active_r[0])
    else $error("slot 0 lost its active mark");

  a_counter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0)
    else $error("process number counter reached zero");

  a_launch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.launch_request |->
      (out_ch.status == pst_pkg::ST_OK) &&
      (out_ch.assigned_id < 15'(pst_pkg::LAUNCH_LIMIT)))
    else $error("launch request without a successful low-numbered create");

  a_create_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    hit && (kind_r == pst_pkg::KIND_CREATE) |=> active_r[$past(chk_idx_r)])
    else $error("create did not mark its slot active");

endmodule

FILE: test/process_slot_table_top_tb.sv
// ----------------------------------------------------------------------------
// process_slot_table_top_tb
// Drives create, terminate and change-priority requests into the process slot
// table with random gaps and receiver stalls. A directed table of edge cases
// runs first, most rows checked against a typed result, then random traffic
// checked against a local model of the slot table.
// ----------------------------------------------------------------------------
module process_slot_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT   = 32;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_GAP      = 16;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    pst_pkg::kind_t     kind;
    logic signed [15:0] process_id;
    logic signed [15:0] priority_value;
    logic [31:0]        exit_value;
    logic               has_message;
  } request_t;

  typedef struct {
    request_t         req;
    bit               fixed;
    pst_pkg::result_t res;
  } table_row_t;

  logic clk;
  logic rst_n;

  pst_in_if  in_ch();
  pst_out_if out_ch();

  process_slot_table_top #(.SLOT_COUNT(SLOT_COUNT)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the slot table
  bit          slot_busy [SLOT_COUNT];
  logic [14:0] slot_number [SLOT_COUNT];
  logic [7:0]  slot_priority [SLOT_COUNT];
  logic [31:0] slot_exit [SLOT_COUNT];
  logic [14:0] number_next;

  pst_pkg::result_t pending_results [$];
  table_row_t       edge_rows [$];
  int               mismatch_count;
  bit               send_no_idle;
  bit               recv_no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic void clear_table();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_busy[i]     = 1'b0;
      slot_number[i]   = '0;
      slot_priority[i] = '0;
      slot_exit[i]     = '0;
    end
    slot_busy[0] = 1'b1;
    number_next  = 15'd1;
  endfunction

  function automatic pst_pkg::result_t apply_request(input request_t r);
    pst_pkg::result_t res;
    int               id;
    int               pri;
    res.status         = pst_pkg::ST_OK;
    res.assigned_id    = '0;
    res.launch_request = 1'b0;
    id  = int'(r.process_id);
    pri = int'(r.priority_value);
    case (r.kind)
      pst_pkg::KIND_CREATE: begin
        if (pri < 0 || pri > pst_pkg::PRIORITY_MAX) begin
          res.status = pst_pkg::ST_PARAM;
        end else begin
          res.status = pst_pkg::ST_FULL;
          for (int i = 1; i < SLOT_COUNT; i++) begin
            if (!slot_busy[i]) begin
              slot_busy[i]       = 1'b1;
              slot_number[i]     = number_next;
              slot_priority[i]   = pri[7:0];
              slot_exit[i]       = '0;
              res.status         = pst_pkg::ST_OK;
              res.assigned_id    = number_next;
              res.launch_request = r.has_message &&
                                   (int'(number_next) < pst_pkg::LAUNCH_LIMIT);
              // counter sticks at its top value
              if (number_next != 15'h7fff) number_next = number_next + 15'd1;
              break;
            end
          end
        end
      end
      pst_pkg::KIND_TERMINATE: begin
        if (id <= 0 || id >= SLOT_COUNT) begin
          res.status = pst_pkg::ST_ID;
        end else begin
          res.status = pst_pkg::ST_MISSING;
          for (int i = 1; i < SLOT_COUNT; i++) begin
            if (slot_busy[i] && int'(slot_number[i]) == id) begin
              slot_busy[i] = 1'b0;
              slot_exit[i] = r.exit_value;
              res.status   = pst_pkg::ST_OK;
              break;
            end
          end
        end
      end
      pst_pkg::KIND_PRIORITY: begin
        // priority is checked before the number
        if (pri < 0 || pri > pst_pkg::PRIORITY_MAX) begin
          res.status = pst_pkg::ST_PARAM;
        end else if (id < 0 || id >= SLOT_COUNT) begin
          res.status = pst_pkg::ST_ID;
        end else begin
          res.status = pst_pkg::ST_MISSING;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_busy[i] && int'(slot_number[i]) == id) begin
              slot_priority[i] = pri[7:0];
              res.status       = pst_pkg::ST_OK;
              break;
            end
          end
        end
      end
      default: res.status = pst_pkg::ST_PARAM;
    endcase
    return res;
  endfunction

  task automatic add_row(input pst_pkg::kind_t k, input int id, input int pri,
                         input logic [31:0] ex, input bit msg, input bit fixed,
                         input pst_pkg::status_t st, input int aid, input bit launch);
    table_row_t row;
    row.req.kind               = k;
    row.req.process_id         = id[15:0];
    row.req.priority_value     = pri[15:0];
    row.req.exit_value         = ex;
    row.req.has_message        = msg;
    row.fixed                  = fixed;
    row.res.status             = st;
    row.res.assigned_id        = aid[14:0];
    row.res.launch_request     = launch;
    edge_rows.push_back(row);
  endtask

  function automatic request_t make_request();
    request_t r;
    int       pick;
    int       slot;
    int       id;
    pick = $urandom_range(0, 99);
    if (pick < 25)      r.kind = pst_pkg::KIND_CREATE;
    else if (pick < 60) r.kind = pst_pkg::KIND_TERMINATE;
    else if (pick < 94) r.kind = pst_pkg::KIND_PRIORITY;
    else                r.kind = pst_pkg::KIND_UNUSED;
    // mostly numbers near the legal range, often one that is live
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      slot = $urandom_range(0, SLOT_COUNT - 1);
      id   = slot_busy[slot] ? int'(slot_number[slot]) : int'($urandom_range(0, 34)) - 1;
    end else if (pick < 8) begin
      id = int'($urandom_range(0, 34)) - 1;
    end else begin
      id = $urandom_range(0, 16'hffff);
    end
    r.process_id     = id[15:0];
    r.priority_value = ($urandom_range(0, 4) != 0) ?
                       16'($urandom_range(0, pst_pkg::PRIORITY_MAX)) : 16'($urandom);
    r.exit_value     = $urandom;
    r.has_message    = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_item(input request_t r, input bit fixed, input pst_pkg::result_t typed);
    int               gap;
    pst_pkg::result_t pred;
    if ($urandom_range(0, 39) == 0) send_no_idle = !send_no_idle;
    gap = send_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.kind           <= r.kind;
    in_ch.process_id     <= r.process_id;
    in_ch.priority_value <= r.priority_value;
    in_ch.exit_value     <= r.exit_value;
    in_ch.has_message    <= r.has_message;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = apply_request(r);
    pending_results.push_back(fixed ? typed : pred);
  endtask

  // receiver: random stalls, checks each result against the oldest expectation
  initial begin : result_check
    int               stall;
    pst_pkg::result_t want;
    out_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_no_idle = !recv_no_idle;
      stall = recv_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_ch.valid === 1'b1));
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with no request pending: status %0d id %0d launch %0b",
                                out_ch.status, out_ch.assigned_id, out_ch.launch_request));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          note_mismatch($sformatf("status expected %0d got %0d", want.status, out_ch.status));
        if (out_ch.assigned_id !== want.assigned_id)
          note_mismatch($sformatf("assigned_id expected %0d got %0d",
                                  want.assigned_id, out_ch.assigned_id));
        if (out_ch.launch_request !== want.launch_request)
          note_mismatch($sformatf("launch_request expected %0b got %0b",
                                  want.launch_request, out_ch.launch_request));
      end
    end
  end

  initial begin : stimulus
    pst_pkg::result_t none;
    int               waited;
    none.status         = pst_pkg::ST_OK;
    none.assigned_id    = '0;
    none.launch_request = 1'b0;
    mismatch_count       = 0;
    send_no_idle         = 1'b0;
    recv_no_idle         = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.kind           = pst_pkg::KIND_CREATE;
    in_ch.process_id     = '0;
    in_ch.priority_value = '0;
    in_ch.exit_value     = '0;
    in_ch.has_message    = 1'b0;
    clear_table();

    // edge cases: priority and number range limits, every kind, table start-up
    add_row(pst_pkg::KIND_CREATE,    0,     0,   32'h0,   1, 1, pst_pkg::ST_OK,      1, 1);
    add_row(pst_pkg::KIND_CREATE,    0,   255,   32'h0,   0, 1, pst_pkg::ST_OK,      2, 0);
    add_row(pst_pkg::KIND_CREATE,    0,   256,   32'h0,   1, 1, pst_pkg::ST_PARAM,   0, 0);
    add_row(pst_pkg::KIND_CREATE,    0,    -1,   32'h0,   1, 1, pst_pkg::ST_PARAM,   0, 0);
    add_row(pst_pkg::KIND_CREATE, 32767, -32768, '1,      0, 1, pst_pkg::ST_PARAM,   0, 0);
    add_row(pst_pkg::KIND_CREATE, -32768, 32767, 32'h0,   1, 1, pst_pkg::ST_PARAM,   0, 0);
    add_row(pst_pkg::KIND_TERMINATE, 0,     0,   32'h0,   0, 1, pst_pkg::ST_ID,      0, 0);
    add_row(pst_pkg::KIND_TERMINATE, -1,    0,   32'h0,   0, 1, pst_pkg::ST_ID,      0, 0);
    add_row(pst_pkg::KIND_TERMINATE, 32,    0,   32'h0,   0, 1, pst_pkg::ST_ID,      0, 0);
    add_row(pst_pkg::KIND_TERMINATE, 32767, -1,  32'h0,   1, 1, pst_pkg::ST_ID,      0, 0);
    add_row(pst_pkg::KIND_TERMINATE, -32768, 0,  32'h0,   0, 1, pst_pkg::ST_ID,      0, 0);
    add_row(pst_pkg::KIND_TERMINATE, 5,     0,   32'h0,   0, 1, pst_pkg::ST_MISSING, 0, 0);
    add_row(pst_pkg::KIND_TERMINATE, 1,     0,   '1,      1, 1, pst_pkg::ST_OK,      0, 0);
    add_row(pst_pkg::KIND_PRIORITY,  0,   255,   32'h0,   0, 1, pst_pkg::ST_OK,      0, 0);
    add_row(pst_pkg::KIND_PRIORITY,  40,  256,   32'h0,   0, 1, pst_pkg::ST_PARAM,   0, 0);
    add_row(pst_pkg::KIND_PRIORITY,  -1,    5,   32'h0,   0, 1, pst_pkg::ST_ID,      0, 0);
    add_row(pst_pkg::KIND_PRIORITY,  32,    0,   32'h0,   0, 1, pst_pkg::ST_ID,      0, 0);
    add_row(pst_pkg::KIND_PRIORITY,  31,    7,   32'h0,   0, 1, pst_pkg::ST_MISSING, 0, 0);
    add_row(pst_pkg::KIND_PRIORITY,  2,     0,   32'h0,   1, 1, pst_pkg::ST_OK,      0, 0);
    add_row(pst_pkg::KIND_PRIORITY,  0, -32768,  32'h0,   0, 1, pst_pkg::ST_PARAM,   0, 0);
    add_row(pst_pkg::KIND_UNUSED,    1,     1,   32'h0,   0, 1, pst_pkg::ST_PARAM,   0, 0);
    add_row(pst_pkg::KIND_UNUSED,    -1,   -1, 32'h80000000, 1, 1, pst_pkg::ST_PARAM, 0, 0);
    // freed slot is reused with the next number
    add_row(pst_pkg::KIND_CREATE,    0,   128,   32'h0,   1, 0, pst_pkg::ST_OK,      0, 0);
    add_row(pst_pkg::KIND_TERMINATE, 3,     0, 32'h7fffffff, 0, 0, pst_pkg::ST_OK,   0, 0);
    add_row(pst_pkg::KIND_PRIORITY,  2,   200,   32'h0,   0, 0, pst_pkg::ST_OK,      0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (edge_rows[i]) send_item(edge_rows[i].req, edge_rows[i].fixed, edge_rows[i].res);
    repeat (RANDOM_ITEMS) send_item(make_request(), 1'b0, none);
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (SLOT_COUNT + 8) @(posedge clk);
    waited = pending_results.size();
    if (waited != 0) note_mismatch($sformatf("%0d results never arrived", waited));

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pst_pkg.sv
rtl/pst_if.sv
rtl/process_slot_table_top.sv
test/process_slot_table_top_tb.sv
